/* src/eurf_pkg.sv */
// Shared constants and types for the encoder unwrap and rate filter.
package eurf_pkg;

    localparam int RAW_W      = 13;
    localparam int SPEED_W    = 16;
    localparam int RATE_W     = 14;
    localparam int TURNS_W    = 32;
    localparam int COUNT_W    = 45;
    localparam int ANGLE_W    = 64;

    localparam int RING_DEPTH = 8;
    localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W      = RATE_W + RING_IDX_W + 1;

    localparam int WRAP_LIMIT      = 6500;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int DEG_PER_TURN    = 360;

    // Width of the signed angle difference times the degrees per turn.
    localparam int DELTA_W     = RAW_W + 1;
    localparam int DELTA_DEG_W = DELTA_W + 10;
    localparam int TURN_DEG_W  = TURNS_W + 10;

    localparam logic FUNC_SEED    = 1'b0;
    localparam logic FUNC_PROCESS = 1'b1;

    localparam logic signed [TURNS_W-1:0] TURNS_MAX = {1'b0, {(TURNS_W-1){1'b1}}};
    localparam logic signed [TURNS_W-1:0] TURNS_MIN = {1'b1, {(TURNS_W-1){1'b0}}};

    // One tracked frame, as it leaves the unwrap stage.
    typedef struct packed {
        logic [RAW_W-1:0]          raw_angle;
        logic signed [TURNS_W-1:0] turns;
        logic signed [RATE_W-1:0]  rate;
        logic signed [SUM_W-1:0]   ring_sum;
        logic signed [SPEED_W-1:0] speed;
    } t_track;

endpackage

/* src/eurf_frame_if.sv */
// Input channel carrying one encoder feedback frame.
interface eurf_frame_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic [eurf_pkg::RAW_W-1:0]             raw_angle;
    logic signed [eurf_pkg::SPEED_W-1:0]    speed_word;

    modport source(output valid, func, raw_angle, speed_word, input ready);
    modport sink(input valid, func, raw_angle, speed_word, output ready);
endinterface

/* src/eurf_result_if.sv */
// Output channel carrying one unwrapped position and rate result.
interface eurf_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [eurf_pkg::COUNT_W-1:0]    continuous_count;
    logic signed [eurf_pkg::ANGLE_W-1:0]    angle_scaled;
    logic signed [eurf_pkg::TURNS_W-1:0]    turn_count;
    logic signed [eurf_pkg::RATE_W-1:0]     step_rate;
    logic signed [eurf_pkg::RATE_W-1:0]     mean_rate;
    logic signed [eurf_pkg::SPEED_W-1:0]    speed_out;

    modport source(output valid, continuous_count, angle_scaled, turn_count, step_rate,
                   mean_rate, speed_out, input ready);
    modport sink(input valid, continuous_count, angle_scaled, turn_count, step_rate,
                 mean_rate, speed_out, output ready);
endinterface

/* src/eurf_track.sv */
// Unwrap state: last angle, saturating turn count and the rate ring with its running sum.
module eurf_track (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  logic                                 i_func,
    input  logic [eurf_pkg::RAW_W-1:0]           i_raw_angle,
    input  logic signed [eurf_pkg::SPEED_W-1:0]  i_speed,
    output eurf_pkg::t_track                     o_track
);

    logic [eurf_pkg::RAW_W-1:0]              r_last_angle;
    logic signed [eurf_pkg::TURNS_W-1:0]     r_turns;
    logic signed [eurf_pkg::RATE_W-1:0]      r_ring [eurf_pkg::RING_DEPTH];
    logic [eurf_pkg::RING_IDX_W-1:0]         r_ring_idx;
    logic signed [eurf_pkg::SUM_W-1:0]       r_ring_sum;

    logic signed [eurf_pkg::TURNS_W-1:0]     n_turns;
    logic signed [eurf_pkg::RATE_W-1:0]      n_rate;
    logic signed [eurf_pkg::SUM_W-1:0]       n_ring_sum;
    logic [eurf_pkg::RING_IDX_W-1:0]         n_ring_idx;
    logic signed [eurf_pkg::DELTA_W:0]       w_diff;
    logic signed [eurf_pkg::DELTA_W:0]       w_rate_wide;
    logic                                    w_process;

    assign w_process = (i_func == eurf_pkg::FUNC_PROCESS);

    always_comb begin
        w_diff = $signed({2'b00, i_raw_angle}) - $signed({2'b00, r_last_angle});
        n_turns = r_turns;
        w_rate_wide = w_diff;
        // A large negative step means the encoder passed zero going forward.
        if (w_diff < -(eurf_pkg::DELTA_W+1)'(eurf_pkg::WRAP_LIMIT)) begin
            if (r_turns != eurf_pkg::TURNS_MAX) begin
                n_turns = r_turns + eurf_pkg::TURNS_W'(1);
            end
            w_rate_wide = w_diff + (eurf_pkg::DELTA_W+1)'(eurf_pkg::COUNTS_PER_TURN);
        end else if (w_diff > (eurf_pkg::DELTA_W+1)'(eurf_pkg::WRAP_LIMIT)) begin
            if (r_turns != eurf_pkg::TURNS_MIN) begin
                n_turns = r_turns - eurf_pkg::TURNS_W'(1);
            end
            w_rate_wide = w_diff - (eurf_pkg::DELTA_W+1)'(eurf_pkg::COUNTS_PER_TURN);
        end
        n_rate = w_rate_wide[eurf_pkg::RATE_W-1:0];
        n_ring_sum = r_ring_sum
                   - eurf_pkg::SUM_W'(r_ring[r_ring_idx])
                   + eurf_pkg::SUM_W'(n_rate);
        if (r_ring_idx == eurf_pkg::RING_IDX_W'(eurf_pkg::RING_DEPTH - 1)) begin
            n_ring_idx = '0;
        end else begin
            n_ring_idx = r_ring_idx + eurf_pkg::RING_IDX_W'(1);
        end

        o_track.raw_angle = i_raw_angle;
        o_track.speed     = i_speed;
        if (w_process) begin
            o_track.turns    = n_turns;
            o_track.rate     = n_rate;
            o_track.ring_sum = n_ring_sum;
        end else begin
            o_track.turns    = r_turns;
            o_track.rate     = '0;
            o_track.ring_sum = r_ring_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_turns      <= '0;
            r_ring_idx   <= '0;
            r_ring_sum   <= '0;
            for (int i = 0; i < eurf_pkg::RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_fire) begin
            r_last_angle <= i_raw_angle;
            if (w_process) begin
                r_turns            <= n_turns;
                r_ring_sum         <= n_ring_sum;
                r_ring[r_ring_idx] <= n_rate;
                r_ring_idx         <= n_ring_idx;
            end
        end
    end

endmodule

/* src/encoder_unwrap_rate_filter_top.sv */
// Top level of the encoder unwrap and rate filter.
// A result word passes through the tracked-frame register and then the output register.
// Throughput: one frame word per cycle; the input is stalled only while both the
// tracked-frame register and the output register are full and the output is held.
// Reset (synchronous, active low) clears the turn count, last angle, rate ring,
// ring sum, ring index and the angle bias, and empties both pipeline registers.
module encoder_unwrap_rate_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [eurf_pkg::RAW_W-1:0]          i_cfg_wdata,
    eurf_frame_if.sink                          i_frame,
    eurf_result_if.source                       o_result
);

    logic [eurf_pkg::RAW_W-1:0]                 r_angle_bias;
    logic                                       r_s1_valid;
    eurf_pkg::t_track                           r_s1;
    logic                                       r_out_valid;
    logic signed [eurf_pkg::COUNT_W-1:0]        r_count;
    logic signed [eurf_pkg::ANGLE_W-1:0]        r_angle;
    logic signed [eurf_pkg::TURNS_W-1:0]        r_turns;
    logic signed [eurf_pkg::RATE_W-1:0]         r_rate;
    logic signed [eurf_pkg::RATE_W-1:0]         r_mean;
    logic signed [eurf_pkg::SPEED_W-1:0]        r_speed;

    eurf_pkg::t_track                           w_track;
    logic                                       w_in_fire;
    logic                                       w_out_load;
    logic signed [eurf_pkg::DELTA_W-1:0]        w_delta;
    logic signed [eurf_pkg::DELTA_DEG_W-1:0]    w_delta_deg;
    logic signed [eurf_pkg::TURN_DEG_W-1:0]     w_turn_deg;
    logic signed [eurf_pkg::ANGLE_W-1:0]        n_angle;
    logic signed [eurf_pkg::SUM_W-1:0]          w_mean_full;
    logic signed [eurf_pkg::COUNT_W-1:0]        n_count;

    assign w_out_load    = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready = !r_s1_valid || w_out_load;
    assign w_in_fire     = i_frame.valid && i_frame.ready;

    eurf_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_in_fire),
        .i_func      (i_frame.func),
        .i_raw_angle (i_frame.raw_angle),
        .i_speed     (i_frame.speed_word),
        .o_track     (w_track)
    );

    // Degrees times 8192: the bias offset scaled by 360, plus turns times 360 shifted
    // up by the 13 count bits of one turn.
    always_comb begin
        w_delta     = $signed({1'b0, r_s1.raw_angle}) - $signed({1'b0, r_angle_bias});
        w_delta_deg = eurf_pkg::DELTA_DEG_W'(w_delta)
                    * eurf_pkg::DELTA_DEG_W'(eurf_pkg::DEG_PER_TURN);
        w_turn_deg  = eurf_pkg::TURN_DEG_W'(r_s1.turns)
                    * eurf_pkg::TURN_DEG_W'(eurf_pkg::DEG_PER_TURN);
        n_angle     = (eurf_pkg::ANGLE_W'(w_turn_deg) <<< eurf_pkg::RAW_W)
                    + eurf_pkg::ANGLE_W'(w_delta_deg);
        n_count     = $signed({r_s1.turns, r_s1.raw_angle});
        // Signed division by the power-of-two ring depth truncates toward zero.
        w_mean_full = r_s1.ring_sum / eurf_pkg::SUM_W'(eurf_pkg::RING_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_bias <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_angle_bias <= i_cfg_wdata;
            end
            if (i_frame.ready) begin
                r_s1_valid <= i_frame.valid;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1 <= w_track;
        end
        if (w_out_load) begin
            r_count <= n_count;
            r_angle <= n_angle;
            r_turns <= r_s1.turns;
            r_rate  <= r_s1.rate;
            r_mean  <= w_mean_full[eurf_pkg::RATE_W-1:0];
            r_speed <= r_s1.speed;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.continuous_count = r_count;
    assign o_result.angle_scaled     = r_angle;
    assign o_result.turn_count       = r_turns;
    assign o_result.step_rate        = r_rate;
    assign o_result.mean_rate        = r_mean;
    assign o_result.speed_out        = r_speed;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_result.ready) |-> !i_frame.ready)
        else $error("input accepted while both pipeline registers are held");

    a_count_has_turns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.continuous_count[eurf_pkg::COUNT_W-1:eurf_pkg::RAW_W]
                            == o_result.turn_count))
        else $error("continuous count disagrees with turn count");

    a_rate_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.step_rate >= -14'sd6500 &&
                            o_result.step_rate <= 14'sd6500))
        else $error("step rate outside the unwrap limit");

    a_mean_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.mean_rate >= -14'sd6500 &&
                            o_result.mean_rate <= 14'sd6500))
        else $error("mean rate outside the unwrap limit");

    a_load_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_result.valid)
        else $error("loaded result word did not appear");
`endif

endmodule

/* verif/encoder_unwrap_rate_filter_top_tb.sv */
// Self-checking testbench for the encoder unwrap and rate filter top level.
module encoder_unwrap_rate_filter_top_tb;

    typedef struct {
        logic signed [eurf_pkg::COUNT_W-1:0] count;
        logic signed [eurf_pkg::ANGLE_W-1:0] angle;
        logic signed [eurf_pkg::TURNS_W-1:0] turns;
        logic signed [eurf_pkg::RATE_W-1:0]  rate;
        logic signed [eurf_pkg::RATE_W-1:0]  mean;
        logic signed [eurf_pkg::SPEED_W-1:0] speed;
    } t_track_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [eurf_pkg::RAW_W-1:0] i_cfg_wdata;

    eurf_frame_if  frame_bus();
    eurf_result_if result_bus();

    encoder_unwrap_rate_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (frame_bus),
        .o_result    (result_bus)
    );

    always #5 i_clk = ~i_clk;

    // Tracker state mirrored from the block.
    logic [eurf_pkg::RAW_W-1:0] bias_setting;
    logic [eurf_pkg::RAW_W-1:0] prev_angle;
    int                         turn_total;
    int                         rate_hist [eurf_pkg::RING_DEPTH];
    int                         hist_pos;
    int                         rate_total;

    t_track_result    pending_results [$];
    int               error_count = 0;
    bit               no_idle = 1'b0;
    int               ready_stall = 0;

    function automatic t_track_result unwrap_frame(logic func,
                                                   logic [eurf_pkg::RAW_W-1:0] raw,
                                                   logic signed [eurf_pkg::SPEED_W-1:0] spd);
        t_track_result res;
        int            step;
        int            rate;
        longint        angle_full;
        rate = 0;
        if (func == eurf_pkg::FUNC_PROCESS) begin
            step = int'(raw) - int'(prev_angle);
            if (step < -eurf_pkg::WRAP_LIMIT) begin
                if (turn_total != eurf_pkg::TURNS_MAX) turn_total++;
                rate = step + eurf_pkg::COUNTS_PER_TURN;
            end else if (step > eurf_pkg::WRAP_LIMIT) begin
                if (turn_total != eurf_pkg::TURNS_MIN) turn_total--;
                rate = step - eurf_pkg::COUNTS_PER_TURN;
            end else begin
                rate = step;
            end
            rate_total = rate_total - rate_hist[hist_pos] + rate;
            rate_hist[hist_pos] = rate;
            hist_pos = (hist_pos + 1) % eurf_pkg::RING_DEPTH;
        end
        prev_angle = raw;
        angle_full = (longint'(raw) - longint'(bias_setting)) * eurf_pkg::DEG_PER_TURN
                   + longint'(turn_total)
                     * (eurf_pkg::DEG_PER_TURN * eurf_pkg::COUNTS_PER_TURN);
        res.count = eurf_pkg::COUNT_W'(longint'(raw)
                    + longint'(turn_total) * eurf_pkg::COUNTS_PER_TURN);
        res.angle = angle_full;
        res.turns = turn_total;
        res.rate  = eurf_pkg::RATE_W'(rate);
        res.mean  = eurf_pkg::RATE_W'(rate_total / eurf_pkg::RING_DEPTH);
        res.speed = spd;
        return res;
    endfunction

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_track_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no frame outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("continuous_count", want.count, result_bus.continuous_count);
                check_field("angle_scaled", want.angle, result_bus.angle_scaled);
                check_field("turn_count", want.turns, result_bus.turn_count);
                check_field("step_rate", want.rate, result_bus.step_rate);
                check_field("mean_rate", want.mean, result_bus.mean_rate);
                check_field("speed_out", want.speed, result_bus.speed_out);
            end
        end
    end

    // Output back-pressure in short random bursts.
    initial begin
        result_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!no_idle && ready_stall == 0 && $urandom_range(0, 5) == 0)
                ready_stall = $urandom_range(1, 3);
            if (ready_stall > 0) begin
                result_bus.ready <= 1'b0;
                ready_stall--;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_frame(logic func, logic [eurf_pkg::RAW_W-1:0] raw,
                              logic signed [eurf_pkg::SPEED_W-1:0] spd);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            frame_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        frame_bus.valid      <= 1'b1;
        frame_bus.func       <= func;
        frame_bus.raw_angle  <= raw;
        frame_bus.speed_word <= spd;
        do @(posedge i_clk); while (!frame_bus.ready);
        pending_results.push_back(unwrap_frame(func, raw, spd));
    endtask

    task automatic wait_for_results();
        frame_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_angle_bias(logic [eurf_pkg::RAW_W-1:0] value);
        wait_for_results();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bias_setting = value;
    endtask

    // Steps of exactly the wrap limit must not wrap; one count more must.
    task automatic test_wrap_thresholds();
        send_frame(eurf_pkg::FUNC_SEED, 13'd0, 16'sd0);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd6500, 16'sd32767);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd0, 16'sh8000);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd6501, 16'sd1);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd0, -16'sd1);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd8191, 16'sd0);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd0, 16'sd0);
        send_frame(eurf_pkg::FUNC_SEED, 13'd8191, 16'sd100);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd8191, -16'sd100);
    endtask

    task automatic test_field_extremes();
        set_angle_bias(13'd8191);
        send_frame(eurf_pkg::FUNC_SEED, 13'd8191, -16'sd1);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'd0, 16'sh5555);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'h0AAA, 16'shAAAA);
        send_frame(eurf_pkg::FUNC_PROCESS, 13'h1555, 16'sh7FFF);
        send_frame(eurf_pkg::FUNC_SEED, 13'd0, 16'sh8000);
    endtask

    // More process words than ring entries, so old rates drop out of the mean.
    task automatic test_ring_wrap();
        logic [eurf_pkg::RAW_W-1:0] pos;
        pos = 13'd7000;
        for (int k = 0; k < eurf_pkg::RING_DEPTH + 1; k++) begin
            pos = pos + 13'd700;
            send_frame(eurf_pkg::FUNC_PROCESS, pos, 16'(k * 37));
        end
    endtask

    // Mostly smooth motion with random content, plus seeds and random jumps.
    task automatic test_random_motion(int count, bit pause_midway);
        int  pos;
        int  vel;
        int  pick;
        logic signed [eurf_pkg::SPEED_W-1:0] spd;
        pos = $urandom_range(0, 8191);
        vel = int'($urandom_range(0, 3000)) - 1500;
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) wait_for_results();
            spd  = eurf_pkg::SPEED_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                pos = $urandom_range(0, 8191);
                send_frame(eurf_pkg::FUNC_SEED, pos[eurf_pkg::RAW_W-1:0], spd);
            end else if (pick < 12) begin
                pos = $urandom_range(0, 8191);
                send_frame(eurf_pkg::FUNC_PROCESS, pos[eurf_pkg::RAW_W-1:0], spd);
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        vel = int'($urandom_range(0, 13200)) - 6600;
                    else
                        vel = int'($urandom_range(0, 3000)) - 1500;
                end
                pos = (pos + vel + 2 * eurf_pkg::COUNTS_PER_TURN) % eurf_pkg::COUNTS_PER_TURN;
                send_frame(eurf_pkg::FUNC_PROCESS, pos[eurf_pkg::RAW_W-1:0], spd);
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        frame_bus.valid      = 1'b0;
        frame_bus.func       = eurf_pkg::FUNC_SEED;
        frame_bus.raw_angle  = '0;
        frame_bus.speed_word = '0;
        bias_setting         = '0;
        prev_angle           = '0;
        turn_total           = 0;
        hist_pos             = 0;
        rate_total           = 0;
        foreach (rate_hist[k]) rate_hist[k] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_wrap_thresholds();
        test_field_extremes();
        test_ring_wrap();

        set_angle_bias(eurf_pkg::RAW_W'($urandom_range(1, 8190)));
        test_random_motion(240, 1'b1);
        set_angle_bias(13'd0);
        test_random_motion(240, 1'b0);
        set_angle_bias(13'd8191);
        test_random_motion(240, 1'b1);
        set_angle_bias(eurf_pkg::RAW_W'($urandom_range(0, 8191)));
        no_idle = 1'b1;
        test_random_motion(240, 1'b0);

        wait_for_results();
        repeat (5) @(posedge i_clk);
        if (error_count == 0)
            $display("encoder_unwrap_rate_filter_top_tb: done, clean");
        else
            $display("encoder_unwrap_rate_filter_top_tb: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("encoder_unwrap_rate_filter_top_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
src/eurf_pkg.sv
src/eurf_frame_if.sv
src/eurf_result_if.sv
src/eurf_track.sv
src/encoder_unwrap_rate_filter_top.sv
verif/encoder_unwrap_rate_filter_top_tb.sv
